>>> src/rfd_pkg.sv
// Shared types and constants for the RLE565 frame decoder.
package rfd_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RUNS,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT_HEADER,
      ST_ZERO_SIZE,
      ST_MISMATCH,
      ST_ZERO_RUN,
      ST_OVERRUN,
      ST_TRAILING,
      ST_SHORT_DATA
   } status_type;

   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_EXP_WIDTH  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_EXP_HEIGHT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CHECK_SIZE = 2'd2;

   // quotient of the cursor divide fits in 16 bits, one bit per step
   localparam int DivSteps = 16;
   localparam int DivStepW = $clog2(DivSteps);

   typedef struct packed {
      logic [15:0] exp_width;
      logic [15:0] exp_height;
      logic        check_size;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quotient;
      logic [15:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic        span_valid;
      logic [15:0] span_row;
      logic [15:0] span_col;
      logic [15:0] span_count;
      logic [15:0] span_color;
      logic        frame_done;
      status_type  status;
   } result_type;

endpackage

>>> src/rfd_if.sv
// Channel interfaces: byte requests, span results and register writes.
interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface rfd_rsp_if import rfd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        span_valid;
   logic [15:0] span_row;
   logic [15:0] span_col;
   logic [15:0] span_count;
   logic [15:0] span_color;
   logic        frame_done;
   status_type  status;

   modport source (output valid, output span_valid, output span_row, output span_col,
                   output span_count, output span_color, output frame_done,
                   output status, input ready);
   modport sink   (input valid, input span_valid, input span_row, input span_col,
                   input span_count, input span_color, input frame_done,
                   input status, output ready);
endinterface

interface rfd_csr_if import rfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [15:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/rle565_frame_decoder_top.sv
// Top level of the RLE565 frame decoder: registers, parser, cursor divider, result stage.
//
//   channel   dir  handshake          payload
//   req_bus   in   valid/ready        data_byte[7:0], end_of_file
//   rsp_bus   out  valid/ready        span_valid, span_row/col/count/color[15:0],
//                                     frame_done, status[2:0]
//   csr_bus   in   valid/ready (=1)   index[1:0], data[15:0]
//
// One byte request per cycle while the cursor divider is idle. The fourth byte of a
// run record that leaves pixels in the frame, unless it ends the file, starts a
// 16-step serial divide of the remaining pixel index by the width; requests stall
// until the new cursor is loaded.
// Synchronous active-high reset clears the frame state and the registers.
// A held result blocks the next request only while rsp_bus.ready is low.
module rle565_frame_decoder_top import rfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   rfd_req_if.sink    req_bus,
   rfd_rsp_if.source  rsp_bus,
   rfd_csr_if.sink    csr_bus
);

   // configuration registers
   logic [15:0] exp_width_ff, exp_width_in;
   logic [15:0] exp_height_ff, exp_height_in;
   logic        check_size_ff, check_size_in;
   cfg_type     cfg;

   logic        fire;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        parse_report;
   result_type  parse_result;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      exp_width_in  = exp_width_ff;
      exp_height_in = exp_height_ff;
      check_size_in = check_size_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_EXP_WIDTH:  exp_width_in  = csr_bus.data;
            CSR_EXP_HEIGHT: exp_height_in = csr_bus.data;
            CSR_CHECK_SIZE: check_size_in = csr_bus.data[0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_width_ff  <= 16'd0;
         exp_height_ff <= 16'd0;
         check_size_ff <= 1'b0;
      end else begin
         exp_width_ff  <= exp_width_in;
         exp_height_ff <= exp_height_in;
         check_size_ff <= check_size_in;
      end
   end

   assign cfg.exp_width  = exp_width_ff;
   assign cfg.exp_height = exp_height_ff;
   assign cfg.check_size = check_size_ff;

   // a byte is taken when the divider is idle and the result slot frees up
   assign req_bus.ready = !div_rsp.busy && (!rsp_valid_ff || rsp_bus.ready);
   assign fire          = req_bus.valid && req_bus.ready;

   rfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (req_bus.data_byte),
      .end_of_file (req_bus.end_of_file),
      .cfg         (cfg),
      .div_rsp     (div_rsp),
      .div_req     (div_req),
      .report      (parse_report),
      .result      (parse_result)
   );

   rfd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_bus.ready) rsp_valid_in = 1'b0;
      if (parse_report) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = parse_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.span_valid = rsp_data_ff.span_valid;
   assign rsp_bus.span_row   = rsp_data_ff.span_row;
   assign rsp_bus.span_col   = rsp_data_ff.span_col;
   assign rsp_bus.span_count = rsp_data_ff.span_count;
   assign rsp_bus.span_color = rsp_data_ff.span_color;
   assign rsp_bus.frame_done = rsp_data_ff.frame_done;
   assign rsp_bus.status     = rsp_data_ff.status;

   // a divide starts only on a byte that emits a span
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (parse_report && parse_result.span_valid))
      else $error("cursor divide started without a span");

   // a span never carries a zero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.span_valid) |-> (rsp_data_ff.span_count != 16'd0))
      else $error("span with zero count");

   // non-span results carry cleared span fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.span_valid) |->
         (rsp_data_ff.span_row == 16'd0 && rsp_data_ff.span_col == 16'd0 &&
          rsp_data_ff.span_count == 16'd0 && rsp_data_ff.span_color == 16'd0))
      else $error("span fields not cleared");

   // a request taken during a divide would be parsed against a stale cursor
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !fire)
      else $error("request accepted while cursor divide runs");

endmodule

>>> src/rfd_divider.sv
// Bit-serial restoring divider for the display cursor: one quotient bit per cycle.
module rfd_divider import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivStepW-1:0] step_ff, step_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         quo_ff, quo_in;   // dividend bits shift out, quotient bits in
   logic [15:0]         dsr_ff, dsr_in;
   logic [16:0]         partial;
   logic [16:0]         trial;

   assign partial = {rem_ff, quo_ff[15]};
   assign trial   = partial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         // upper half is already below the divisor since the quotient fits 16 bits
         rem_in  = div_req.dividend[31:16];
         quo_in  = div_req.dividend[15:0];
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = partial[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DivStepW'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = busy_ff | done_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> src/rfd_parser.sv
// Byte-level frame parser: header, run records, cursor and error tracking.
module rfd_parser import rfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  data_byte,
   input  logic        end_of_file,
   input  cfg_type     cfg,
   input  div_rsp_type div_rsp,
   output div_req_type div_req,
   output logic        report,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] left_ff, left_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   status_type  err_ff, err_in;

   logic [15:0] word;
   logic [31:0] area;
   logic [32:0] diff;
   logic        over;
   logic [31:0] last_idx;
   logic        hdr_final, hdr_zero, hdr_mismatch, hdr_ok;
   logic        run_final, run_zero, run_span, run_over, run_end;
   logic        trailing;
   logic        raise_any;
   status_type  raise_code;
   phase_type   phase_after;
   status_type  err_after;

   assign word     = {data_byte, low_ff};
   assign area     = {16'd0, width_ff} * {16'd0, word};
   assign diff     = {1'b0, left_ff} - {17'd0, count_ff};
   assign over     = diff[32];
   assign last_idx = left_ff + ~{16'd0, count_ff};   // pixels left after run, minus one

   assign hdr_final    = fire && (phase_ff == PH_HEADER) && (pos_ff == 2'd3);
   assign hdr_zero     = hdr_final && ((width_ff == 16'd0) || (word == 16'd0));
   assign hdr_mismatch = hdr_final && !hdr_zero && cfg.check_size &&
                         ((width_ff != cfg.exp_width) || (word != cfg.exp_height));
   assign hdr_ok       = hdr_final && !hdr_zero && !hdr_mismatch;

   assign run_final = fire && (phase_ff == PH_RUNS) && (pos_ff == 2'd3);
   assign run_zero  = run_final && (count_ff == 16'd0);
   assign run_span  = run_final && (count_ff != 16'd0);
   assign run_over  = run_span && over;
   assign run_end   = run_span && !over && (diff[31:0] == 32'd0);
   assign trailing  = fire && (phase_ff == PH_DONE);

   assign raise_any = hdr_zero || hdr_mismatch || run_zero || run_over || trailing;

   always_comb begin
      raise_code = ST_OK;
      if (hdr_zero)          raise_code = ST_ZERO_SIZE;
      else if (hdr_mismatch) raise_code = ST_MISMATCH;
      else if (run_zero)     raise_code = ST_ZERO_RUN;
      else if (run_over)     raise_code = ST_OVERRUN;
      else if (trailing)     raise_code = ST_TRAILING;
   end

   always_comb begin
      if (raise_any)    phase_after = PH_ERROR;
      else if (hdr_ok)  phase_after = PH_RUNS;
      else if (run_end) phase_after = PH_DONE;
      else              phase_after = phase_ff;
   end

   assign err_after = raise_any ? raise_code : err_ff;

   // next state
   always_comb begin
      phase_in = phase_after;
      pos_in   = pos_ff;
      low_in   = low_ff;
      width_in = width_ff;
      count_in = count_ff;
      left_in  = left_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      err_in   = err_after;
      div_req.start    = 1'b0;
      div_req.dividend = last_idx;
      div_req.divisor  = width_ff;
      if (fire && ((phase_ff == PH_HEADER) || (phase_ff == PH_RUNS))) begin
         case (pos_ff)
            2'd0, 2'd2: begin
               low_in = data_byte;
               pos_in = pos_ff + 2'd1;
            end
            2'd1: begin
               if (phase_ff == PH_HEADER) width_in = word;
               else                       count_in = word;
               pos_in = 2'd2;
            end
            default: begin
               pos_in = 2'd0;
               if (hdr_ok) begin
                  left_in = area;
                  row_in  = word - 16'd1;
                  col_in  = width_ff - 16'd1;
               end
               if (run_span) begin
                  left_in = over ? 32'd0 : diff[31:0];
                  if (!over && !run_end && !end_of_file) begin
                     div_req.start = 1'b1;
                  end
               end
            end
         endcase
      end
      if (div_rsp.done) begin
         row_in = div_rsp.quotient;
         col_in = div_rsp.remainder;
      end
      if (fire && end_of_file) begin
         phase_in = PH_HEADER;
         pos_in   = 2'd0;
         low_in   = 8'd0;
         width_in = 16'd0;
         count_in = 16'd0;
         left_in  = 32'd0;
         row_in   = 16'd0;
         col_in   = 16'd0;
         err_in   = ST_OK;
      end
   end

   // outputs
   always_comb begin
      report = raise_any || run_span || (fire && end_of_file);
      result = '0;
      if (run_span) begin
         result.span_valid = 1'b1;
         result.span_row   = row_ff;
         result.span_col   = col_ff;
         result.span_count = over ? left_ff[15:0] : count_ff;
         result.span_color = word;
      end
      result.frame_done = fire && end_of_file;
      result.status     = raise_code;
      if (fire && end_of_file) begin
         if (err_after != ST_OK) begin
            result.status = err_after;
         end else begin
            case (phase_after)
               PH_HEADER: result.status = ST_SHORT_HEADER;
               PH_RUNS:   result.status = ST_SHORT_DATA;
               default:   result.status = ST_OK;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= 2'd0;
         low_ff   <= 8'd0;
         width_ff <= 16'd0;
         count_ff <= 16'd0;
         left_ff  <= 32'd0;
         row_ff   <= 16'd0;
         col_ff   <= 16'd0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         low_ff   <= low_in;
         width_ff <= width_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         err_ff   <= err_in;
      end
   end

endmodule

>>> sim/rfd_checker.sv
// Span checker: tracks the decoder state from observed requests and checks every result.
module rfd_span_checker import rfd_pkg::*; (
   input  logic clock,
   input  logic reset,
   rfd_req_if   req_mon,
   rfd_rsp_if   rsp_mon,
   rfd_csr_if   csr_mon,
   output int   fault_count,
   output int   outstanding
);

   // register copies
   logic [15:0] exp_width;
   logic [15:0] exp_height;
   logic        size_check;

   // frame parse state
   phase_type   phase;
   logic [1:0]  byte_pos;
   logic [7:0]  low_hold;
   logic [15:0] img_width;
   logic [15:0] img_height;
   logic [15:0] run_len;
   logic [31:0] pixels_left;
   logic [15:0] cur_row;
   logic [15:0] cur_col;
   status_type  fault_code;

   result_type  awaited_spans[$];

   task automatic clear_frame();
      phase       = PH_HEADER;
      byte_pos    = '0;
      low_hold    = '0;
      img_width   = '0;
      img_height  = '0;
      run_len     = '0;
      pixels_left = '0;
      cur_row     = '0;
      cur_col     = '0;
      fault_code  = ST_OK;
   endtask

   // display position of the last pixel still to be covered
   task automatic place_cursor();
      logic [31:0] idx;
      if (pixels_left == '0 || img_width == '0) begin
         cur_row = '0;
         cur_col = '0;
      end else begin
         idx     = pixels_left - 32'd1;
         cur_row = 16'(idx / 32'(img_width));
         cur_col = 16'(idx % 32'(img_width));
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eof,
                              output bit emit, output result_type res);
      logic [15:0] word;
      logic [31:0] take;
      bit          over;
      bit          was_fault;
      word      = {b, low_hold};
      was_fault = (phase == PH_ERROR);
      emit      = 1'b0;
      res       = '0;
      case (phase)
         PH_HEADER: begin
            case (byte_pos)
               2'd0, 2'd2: begin
                  low_hold = b;
                  byte_pos = byte_pos + 2'd1;
               end
               2'd1: begin
                  img_width = word;
                  byte_pos  = 2'd2;
               end
               default: begin
                  img_height = word;
                  byte_pos   = 2'd0;
                  if (img_width == '0 || img_height == '0) begin
                     phase      = PH_ERROR;
                     fault_code = ST_ZERO_SIZE;
                  end else if (size_check && (img_width != exp_width ||
                                              img_height != exp_height)) begin
                     phase      = PH_ERROR;
                     fault_code = ST_MISMATCH;
                  end else begin
                     pixels_left = 32'(img_width) * 32'(img_height);
                     place_cursor();
                     phase = PH_RUNS;
                  end
               end
            endcase
         end
         PH_RUNS: begin
            case (byte_pos)
               2'd0, 2'd2: begin
                  low_hold = b;
                  byte_pos = byte_pos + 2'd1;
               end
               2'd1: begin
                  run_len  = word;
                  byte_pos = 2'd2;
               end
               default: begin
                  byte_pos = 2'd0;
                  if (run_len == '0) begin
                     phase      = PH_ERROR;
                     fault_code = ST_ZERO_RUN;
                  end else begin
                     take = 32'(run_len);
                     over = take > pixels_left;
                     if (over) take = pixels_left;
                     emit           = 1'b1;
                     res.span_valid = 1'b1;
                     res.span_row   = cur_row;
                     res.span_col   = cur_col;
                     res.span_count = take[15:0];
                     res.span_color = word;
                     pixels_left    = pixels_left - take;
                     place_cursor();
                     if (over) begin
                        phase      = PH_ERROR;
                        fault_code = ST_OVERRUN;
                     end else if (pixels_left == '0) begin
                        phase = PH_DONE;
                     end
                  end
               end
            endcase
         end
         PH_DONE: begin
            phase      = PH_ERROR;
            fault_code = ST_TRAILING;
         end
         default: ;
      endcase

      // a fresh error is reported once
      if (phase == PH_ERROR && !was_fault) begin
         emit       = 1'b1;
         res.status = fault_code;
      end

      if (eof) begin
         emit           = 1'b1;
         res.frame_done = 1'b1;
         if (fault_code != ST_OK) res.status = fault_code;
         else if (phase == PH_HEADER) res.status = ST_SHORT_HEADER;
         else if (phase == PH_RUNS) res.status = ST_SHORT_DATA;
         else res.status = ST_OK;
         clear_frame();
      end
   endtask

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      bit         emit;
      result_type predicted;
      if (reset) begin
         exp_width   = '0;
         exp_height  = '0;
         size_check  = 1'b0;
         fault_count = 0;
         clear_frame();
         awaited_spans.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_EXP_WIDTH:  exp_width  = csr_mon.data;
               CSR_EXP_HEIGHT: exp_height = csr_mon.data;
               CSR_CHECK_SIZE: size_check = csr_mon.data[0];
               default: ;
            endcase
         end
         // request first, so a prediction is queued before any result is compared
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.data_byte, req_mon.end_of_file, emit, predicted);
            if (emit) awaited_spans.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_spans.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result with none pending, status %0d", $time,
                           rsp_mon.status);
            end else begin
               predicted = awaited_spans.pop_front();
               compare_field("span_valid", 16'(predicted.span_valid),
                             16'(rsp_mon.span_valid));
               compare_field("span_row", predicted.span_row, rsp_mon.span_row);
               compare_field("span_col", predicted.span_col, rsp_mon.span_col);
               compare_field("span_count", predicted.span_count, rsp_mon.span_count);
               compare_field("span_color", predicted.span_color, rsp_mon.span_color);
               compare_field("frame_done", 16'(predicted.frame_done),
                             16'(rsp_mon.frame_done));
               compare_field("status", 16'(predicted.status), 16'(rsp_mon.status));
            end
         end
      end
      outstanding = awaited_spans.size();
   end

endmodule

>>> sim/tb_top.sv
// Testbench top for the RLE565 frame decoder: stimulus, flow control and verdict.
module tb_top import rfd_pkg::*; ();

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   // a run record holds the byte side while its cursor divide runs
   localparam int SETTLE_CYCLES = 40;
   // no handshake at all for this long means the block is stuck
   localparam int QUIET_LIMIT   = 2000;
   // receiver hold-off that backs the block up into its request side
   localparam int LONG_STALL    = 250;
   // index with no register behind it, writes must be dropped
   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;

   rfd_req_if req_if ();
   rfd_rsp_if rsp_if ();
   rfd_csr_if csr_if ();

   int fault_count;
   int outstanding;

   // flow control knobs, percent of cycles spent idle
   int send_idle;
   int recv_idle;
   int bytes_sent;
   int quiet_cycles;
   int stall_left;
   bit long_stall_req;
   bit long_stall_done;

   // frame size the generator favors, usually the one the registers expect
   logic [15:0] pref_width;
   logic [15:0] pref_height;
   int          pref_pct;

   // bytes of the frame being built: {end_of_file, data_byte}
   logic [8:0]  frame_bytes[$];

   rle565_frame_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   rfd_span_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Receiver: random ready at the falling edge, plus one long hold-off on request.
   // Every branch makes exactly one assignment to ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (long_stall_req && !long_stall_done) begin
         rsp_if.ready <= 1'b0;
         stall_left      = LONG_STALL - 1;
         long_stall_done = 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte request; entered and left at a falling edge. Valid is only
   // lowered during idle gaps, so back-to-back requests keep it high.
   task automatic push_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b;
      req_if.end_of_file <= eof;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // little-endian word into the frame under construction
   task automatic put_word(input logic [15:0] w);
      frame_bytes.push_back({1'b0, w[7:0]});
      frame_bytes.push_back({1'b0, w[15:8]});
   endtask

   task automatic mark_eof();
      logic [8:0] last;
      last = frame_bytes.pop_back();
      frame_bytes.push_back(last | 9'h100);
   endtask

   task automatic stream_frame();
      foreach (frame_bytes[i]) push_byte(frame_bytes[i][7:0], frame_bytes[i][8]);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   // all registers plus a write to the empty index, which must change nothing
   task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] chk);
      write_reg(CSR_EXP_WIDTH, w);
      write_reg(CSR_EXP_HEIGHT, h);
      write_reg(CSR_CHECK_SIZE, chk);
      write_reg(CSR_UNUSED, 16'($urandom));
      csr_if.valid <= 1'b0;
   endtask

   // Let the block go quiet: every result in, then time for the last span record
   // to finish its cursor divide.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random frame. Mostly well-formed files; the rest are noise, zero sizes,
   // zero-length runs, overruns, trailing junk and truncated files.
   task automatic build_frame();
      int          kind;
      int          pick;
      int          zero_at;
      int          over_at;
      int          runs;
      int          n;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] cnt;
      logic [31:0] left;
      frame_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 5) begin
         repeat ($urandom_range(1, 8)) frame_bytes.push_back({1'b0, 8'($urandom)});
      end else begin
         pick = $urandom_range(99);
         if (pick < pref_pct) begin
            w = pref_width;
            h = pref_height;
         end else if (pick < 90) begin
            w = 16'($urandom_range(1, 7));
            h = 16'($urandom_range(1, 5));
         end else begin
            // wide frame, only a few records of it get sent
            w = 16'($urandom_range(1, 65535));
            h = 16'($urandom_range(1, 3));
         end
         if (kind < 9) begin
            if ($urandom_range(1)) w = '0;
            else h = '0;
         end
         put_word(w);
         put_word(h);
         left    = 32'(w) * 32'(h);
         zero_at = (kind >= 9 && kind < 14) ? $urandom_range(0, 2) : -1;
         over_at = (kind >= 14 && kind < 20) ? $urandom_range(0, 2) : -1;
         runs    = 0;
         while (left != '0 && runs < 10) begin
            if (runs == zero_at) begin
               put_word('0);
               put_word(16'($urandom));
               break;
            end
            if (runs == over_at)
               cnt = (left < 32'hFFF0) ? 16'(left + $urandom_range(1, 9)) : 16'hFFFF;
            else if (left <= 32'hFFFF && $urandom_range(2) == 0)
               cnt = left[15:0];
            else
               cnt = 16'($urandom_range(1, (left > 32'hFFFF) ? 32'hFFFF : left));
            put_word(cnt);
            put_word(16'($urandom));
            left = (32'(cnt) > left) ? '0 : left - 32'(cnt);
            runs++;
         end
         if (kind >= 20 && kind < 26) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back({1'b0, 8'($urandom)});
         end else if (kind >= 26 && kind < 33) begin
            n = frame_bytes.size();
            repeat ($urandom_range(1, n - 1)) void'(frame_bytes.pop_back());
         end
      end
      mark_eof();
   endtask

   // random frames until the running byte count reaches the target
   task automatic run_phase(input int s_idle, input int r_idle, input int target);
      send_idle = s_idle;
      recv_idle = r_idle;
      while (bytes_sent < target) begin
         build_frame();
         stream_frame();
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.end_of_file = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      send_idle          = 0;
      recv_idle          = 0;
      bytes_sent         = 0;
      stall_left         = 0;
      long_stall_req     = 1'b0;
      long_stall_done    = 1'b0;
      pref_width         = '0;
      pref_height        = '0;
      pref_pct           = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: size check off; sender idles 29%, receiver 47%.
      program_regs(16'h0000, 16'h0000, 16'h0000);
      send_idle = 29;
      recv_idle = 47;

      // lone end-of-file byte: header never started
      frame_bytes.delete();
      frame_bytes.push_back(9'h1FF);
      stream_frame();
      // zero width, error and end of file on the same byte
      frame_bytes.delete();
      put_word(16'h0000);
      put_word(16'h0003);
      mark_eof();
      stream_frame();
      // largest frame, largest run, then a zero-length run ending the file
      frame_bytes.delete();
      put_word(16'hFFFF);
      put_word(16'hFFFF);
      put_word(16'hFFFF);
      put_word(16'hFFFF);
      put_word(16'h0000);
      put_word(16'h0000);
      mark_eof();
      stream_frame();
      // one-pixel frame overrun by its first run, file ends on that record
      frame_bytes.delete();
      put_word(16'h0001);
      put_word(16'h0001);
      put_word(16'h0002);
      put_word(16'h5AA5);
      mark_eof();
      stream_frame();

      run_phase(29, 47, 150);
      wait_drained();

      // Phase 2: size check on with a small frame; idling swapped.
      pref_width  = 16'($urandom_range(1, 6));
      pref_height = 16'($urandom_range(1, 4));
      pref_pct    = 75;
      program_regs(pref_width, pref_height, {15'($urandom), 1'b1});
      run_phase(47, 29, 300);
      wait_drained();

      // Phase 3: largest expected size, no idling, one long receiver hold-off
      // while requests keep coming.
      pref_width  = 16'hFFFF;
      pref_height = 16'hFFFF;
      pref_pct    = 60;
      program_regs(pref_width, pref_height, 16'hFFFF);
      long_stall_req = 1'b1;
      run_phase(0, 0, 375);
      wait_drained();

      // Phase 4: check off again with every bit but bit 0 of its write set.
      pref_width  = 16'($urandom);
      pref_height = 16'($urandom);
      pref_pct    = 0;
      program_regs(pref_width, pref_height, 16'hFFFE);
      run_phase(0, 0, 450);
      wait_drained();

      if (fault_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
